// ===== sv/tmi_pkg.sv =====
// Shared types and constants for the triclinic minimum image pipeline.
// No dependencies; every other file takes names from here by scope.
package tmi_pkg;

    localparam int WORD_W   = 32;
    localparam int CFG_W    = 64;
    localparam int ADDR_W   = 6;
    localparam int VEC_W    = 3 * WORD_W;

    // Rounding shifts of the two matrix products (Q18.46 to Q2.30, to Q16.16)
    localparam int FWD_SHIFT = 16;
    localparam int BACK_SHIFT = 30;

    // Side payload carried alongside the products
    localparam int FWD_SIDE_W  = VEC_W;
    localparam int BACK_SIDE_W = VEC_W + 1;

    // One half and one period in Q2.30
    localparam logic signed [WORD_W-1:0] HALF_Q30 = 32'sh2000_0000;
    localparam logic signed [WORD_W-1:0] ONE_Q30  = 32'sh4000_0000;

    // Register indexes (byte address is 8 * index)
    localparam logic [2:0] REG_BOX_XX_YY = 3'd0;
    localparam logic [2:0] REG_BOX_ZZ_YX = 3'd1;
    localparam logic [2:0] REG_BOX_ZX_ZY = 3'd2;
    localparam logic [2:0] REG_INV_XX_YY = 3'd3;
    localparam logic [2:0] REG_INV_ZZ_YX = 3'd4;
    localparam logic [2:0] REG_INV_ZX_ZY = 3'd5;

    // Upper-triangular 3x3 matrix, each entry a signed 32-bit word
    typedef struct packed {
        logic [WORD_W-1:0] xx;
        logic [WORD_W-1:0] yy;
        logic [WORD_W-1:0] zz;
        logic [WORD_W-1:0] yx;
        logic [WORD_W-1:0] zx;
        logic [WORD_W-1:0] zy;
    } t_tri_mat;

endpackage

// ===== sv/triclinic_minimum_image.sv =====
// Triclinic minimum image: fractional map, single wrap, back map, saturate.
// Accepts one request per cycle sustained while the output is not stalled; the
// six-stage pipeline has a multiply stage and a round/sum stage per matrix product,
// a wrap stage and an output stage. Per-stage ready fills bubbles under stall.
// Synchronous active-low reset clears all valid bits and the six
// matrix registers to zero. Depends on tmi_pkg, tmi_cfg_regs, tmi_tri_mul, tmi_wrap.
module triclinic_minimum_image (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tmi_pkg::ADDR_W-1:0]         paddr,
    input  logic [tmi_pkg::CFG_W-1:0]          pwdata,
    output logic [tmi_pkg::CFG_W-1:0]          prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [tmi_pkg::WORD_W-1:0]  i_rel_x,
    input  logic signed [tmi_pkg::WORD_W-1:0]  i_rel_y,
    input  logic signed [tmi_pkg::WORD_W-1:0]  i_rel_z,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [tmi_pkg::WORD_W-1:0]  o_img_x,
    output logic signed [tmi_pkg::WORD_W-1:0]  o_img_y,
    output logic signed [tmi_pkg::WORD_W-1:0]  o_img_z,
    output logic                               o_wrapped
);

    localparam int W = tmi_pkg::WORD_W;

    tmi_pkg::t_tri_mat box, inv;

    logic                          fwd_valid, fwd_ready;
    logic signed [W-1:0]           fwd_q_x, fwd_q_y, fwd_q_z;
    logic [tmi_pkg::VEC_W-1:0]     fwd_rel;

    logic                          wrp_valid, wrp_ready;
    logic signed [W-1:0]           wrp_q_x, wrp_q_y, wrp_q_z;
    logic                          wrp_hit;
    logic [tmi_pkg::VEC_W-1:0]     wrp_rel;

    logic                          bck_valid, bck_ready;
    logic signed [W-1:0]           bck_x, bck_y, bck_z;
    logic [tmi_pkg::BACK_SIDE_W-1:0] bck_side;
    logic                          bck_hit;
    logic [tmi_pkg::VEC_W-1:0]     bck_rel;

    logic                          r_out_valid;
    logic signed [W-1:0]           r_img_x, r_img_y, r_img_z;
    logic                          r_wrapped;
    logic signed [W-1:0]           n_img_x, n_img_y, n_img_z;

    tmi_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_box   (box),
        .o_inv   (inv)
    );

    tmi_tri_mul #(
        .SHIFT  (tmi_pkg::FWD_SHIFT),
        .SIDE_W (tmi_pkg::FWD_SIDE_W)
    ) u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (inv),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_v_x   (i_rel_x),
        .i_v_y   (i_rel_y),
        .i_v_z   (i_rel_z),
        .i_side  ({i_rel_x, i_rel_y, i_rel_z}),
        .o_valid (fwd_valid),
        .i_ready (fwd_ready),
        .o_s_x   (fwd_q_x),
        .o_s_y   (fwd_q_y),
        .o_s_z   (fwd_q_z),
        .o_side  (fwd_rel)
    );

    tmi_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fwd_valid),
        .o_ready (fwd_ready),
        .i_q_x   (fwd_q_x),
        .i_q_y   (fwd_q_y),
        .i_q_z   (fwd_q_z),
        .i_rel   (fwd_rel),
        .o_valid (wrp_valid),
        .i_ready (wrp_ready),
        .o_q_x   (wrp_q_x),
        .o_q_y   (wrp_q_y),
        .o_q_z   (wrp_q_z),
        .o_hit   (wrp_hit),
        .o_rel   (wrp_rel)
    );

    tmi_tri_mul #(
        .SHIFT  (tmi_pkg::BACK_SHIFT),
        .SIDE_W (tmi_pkg::BACK_SIDE_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (box),
        .i_valid (wrp_valid),
        .o_ready (wrp_ready),
        .i_v_x   (wrp_q_x),
        .i_v_y   (wrp_q_y),
        .i_v_z   (wrp_q_z),
        .i_side  ({wrp_hit, wrp_rel}),
        .o_valid (bck_valid),
        .i_ready (bck_ready),
        .o_s_x   (bck_x),
        .o_s_y   (bck_y),
        .o_s_z   (bck_z),
        .o_side  (bck_side)
    );

    assign bck_hit = bck_side[tmi_pkg::VEC_W];
    assign bck_rel = bck_side[tmi_pkg::VEC_W-1:0];

    // Pass the request vector through untouched when no axis wrapped
    always_comb begin
        if (bck_hit) begin
            n_img_x = bck_x;
            n_img_y = bck_y;
            n_img_z = bck_z;
        end else begin
            n_img_x = $signed(bck_rel[3*W-1:2*W]);
            n_img_y = $signed(bck_rel[2*W-1:W]);
            n_img_z = $signed(bck_rel[W-1:0]);
        end
    end

    assign bck_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (bck_ready) begin
            r_out_valid <= bck_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bck_ready && bck_valid) begin
            r_img_x   <= n_img_x;
            r_img_y   <= n_img_y;
            r_img_z   <= n_img_z;
            r_wrapped <= bck_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_img_x     = r_img_x;
    assign o_img_y     = r_img_y;
    assign o_img_z     = r_img_z;
    assign o_wrapped   = r_wrapped;

endmodule

// ===== sv/tmi_cfg_regs.sv =====
// APB-style register file holding the box and inverse box matrices.
// Depends on tmi_pkg for register indexes and the matrix struct.
module tmi_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmi_pkg::ADDR_W-1:0]  paddr,
    input  logic [tmi_pkg::CFG_W-1:0]   pwdata,
    output logic [tmi_pkg::CFG_W-1:0]   prdata,
    output logic                        pready,
    output tmi_pkg::t_tri_mat           o_box,
    output tmi_pkg::t_tri_mat           o_inv
);

    logic [tmi_pkg::CFG_W-1:0] r_box_xx_yy, r_box_zz_yx, r_box_zx_zy;
    logic [tmi_pkg::CFG_W-1:0] r_inv_xx_yy, r_inv_zz_yx, r_inv_zx_zy;
    logic [2:0]                reg_idx;
    logic                      wr_en;

    assign reg_idx = paddr[tmi_pkg::ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_xx_yy <= '0;
            r_box_zz_yx <= '0;
            r_box_zx_zy <= '0;
            r_inv_xx_yy <= '0;
            r_inv_zz_yx <= '0;
            r_inv_zx_zy <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                tmi_pkg::REG_BOX_XX_YY: r_box_xx_yy <= pwdata;
                tmi_pkg::REG_BOX_ZZ_YX: r_box_zz_yx <= pwdata;
                tmi_pkg::REG_BOX_ZX_ZY: r_box_zx_zy <= pwdata;
                tmi_pkg::REG_INV_XX_YY: r_inv_xx_yy <= pwdata;
                tmi_pkg::REG_INV_ZZ_YX: r_inv_zz_yx <= pwdata;
                tmi_pkg::REG_INV_ZX_ZY: r_inv_zx_zy <= pwdata;
                default: ;  // drop writes beyond the list
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tmi_pkg::REG_BOX_XX_YY: prdata = r_box_xx_yy;
            tmi_pkg::REG_BOX_ZZ_YX: prdata = r_box_zz_yx;
            tmi_pkg::REG_BOX_ZX_ZY: prdata = r_box_zx_zy;
            tmi_pkg::REG_INV_XX_YY: prdata = r_inv_xx_yy;
            tmi_pkg::REG_INV_ZZ_YX: prdata = r_inv_zz_yx;
            tmi_pkg::REG_INV_ZX_ZY: prdata = r_inv_zx_zy;
            default:                prdata = '0;
        endcase
    end

    assign o_box.xx = r_box_xx_yy[63:32];
    assign o_box.yy = r_box_xx_yy[31:0];
    assign o_box.zz = r_box_zz_yx[63:32];
    assign o_box.yx = r_box_zz_yx[31:0];
    assign o_box.zx = r_box_zx_zy[63:32];
    assign o_box.zy = r_box_zx_zy[31:0];

    assign o_inv.xx = r_inv_xx_yy[63:32];
    assign o_inv.yy = r_inv_xx_yy[31:0];
    assign o_inv.zz = r_inv_zz_yx[63:32];
    assign o_inv.yx = r_inv_zz_yx[31:0];
    assign o_inv.zx = r_inv_zx_zy[63:32];
    assign o_inv.zy = r_inv_zx_zy[31:0];

endmodule

// ===== sv/tmi_tri_mul.sv =====
// Two-stage upper-triangular matrix times vector: products, then round/sum/saturate.
// Depends on tmi_pkg for the matrix struct and word width.
module tmi_tri_mul #(
    parameter int SHIFT  = tmi_pkg::FWD_SHIFT,
    parameter int SIDE_W = tmi_pkg::FWD_SIDE_W
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tmi_pkg::t_tri_mat                  i_mat,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [tmi_pkg::WORD_W-1:0]  i_v_x,
    input  logic signed [tmi_pkg::WORD_W-1:0]  i_v_y,
    input  logic signed [tmi_pkg::WORD_W-1:0]  i_v_z,
    input  logic [SIDE_W-1:0]                  i_side,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [tmi_pkg::WORD_W-1:0]  o_s_x,
    output logic signed [tmi_pkg::WORD_W-1:0]  o_s_y,
    output logic signed [tmi_pkg::WORD_W-1:0]  o_s_z,
    output logic [SIDE_W-1:0]                  o_side
);

    localparam int PW = 2 * tmi_pkg::WORD_W;
    localparam int SW = PW + 2;
    localparam logic signed [PW-1:0] RND = PW'(1) << (SHIFT - 1);

    function automatic logic signed [tmi_pkg::WORD_W-1:0] sat_word(
        input logic signed [SW-1:0] v
    );
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'(32'sh7FFF_FFFF);
        lo = SW'(32'sh8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end else begin
            return v[tmi_pkg::WORD_W-1:0];
        end
    endfunction

    // Stage 1: six products
    logic                 r_p_valid;
    logic signed [PW-1:0] r_px0, r_px1, r_px2, r_py0, r_py1, r_pz0;
    logic [SIDE_W-1:0]    r_p_side;
    logic                 p_ready;

    // Stage 2: rounded, summed, saturated
    logic                               r_s_valid;
    logic signed [tmi_pkg::WORD_W-1:0]  r_s_x, r_s_y, r_s_z;
    logic [SIDE_W-1:0]                  r_s_side;
    logic                               s_ready;

    logic signed [PW-1:0] tx0, tx1, tx2, ty0, ty1, tz0;
    logic signed [SW-1:0] sum_x, sum_y, sum_z;
    logic signed [tmi_pkg::WORD_W-1:0] n_s_x, n_s_y, n_s_z;

    assign s_ready = !r_s_valid || i_ready;
    assign p_ready = !r_p_valid || s_ready;
    assign o_ready = p_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (p_ready) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_ready && i_valid) begin
            r_px0    <= $signed(i_mat.xx) * i_v_x;
            r_px1    <= $signed(i_mat.yx) * i_v_y;
            r_px2    <= $signed(i_mat.zx) * i_v_z;
            r_py0    <= $signed(i_mat.yy) * i_v_y;
            r_py1    <= $signed(i_mat.zy) * i_v_z;
            r_pz0    <= $signed(i_mat.zz) * i_v_z;
            r_p_side <= i_side;
        end
    end

    // Round to nearest, ties toward plus infinity
    always_comb begin
        tx0   = (r_px0 + RND) >>> SHIFT;
        tx1   = (r_px1 + RND) >>> SHIFT;
        tx2   = (r_px2 + RND) >>> SHIFT;
        ty0   = (r_py0 + RND) >>> SHIFT;
        ty1   = (r_py1 + RND) >>> SHIFT;
        tz0   = (r_pz0 + RND) >>> SHIFT;
        sum_x = SW'(tx0) + SW'(tx1) + SW'(tx2);
        sum_y = SW'(ty0) + SW'(ty1);
        sum_z = SW'(tz0);
        n_s_x = sat_word(sum_x);
        n_s_y = sat_word(sum_y);
        n_s_z = sat_word(sum_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (s_ready) begin
            r_s_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && r_p_valid) begin
            r_s_x    <= n_s_x;
            r_s_y    <= n_s_y;
            r_s_z    <= n_s_z;
            r_s_side <= r_p_side;
        end
    end

    assign o_valid = r_s_valid;
    assign o_s_x   = r_s_x;
    assign o_s_y   = r_s_y;
    assign o_s_z   = r_s_z;
    assign o_side  = r_s_side;

endmodule

// ===== sv/tmi_wrap.sv =====
// Single-wrap stage: shift each fractional component by one period at most.
// Depends on tmi_pkg for the Q2.30 half and one constants.
module tmi_wrap (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [tmi_pkg::WORD_W-1:0]  i_q_x,
    input  logic signed [tmi_pkg::WORD_W-1:0]  i_q_y,
    input  logic signed [tmi_pkg::WORD_W-1:0]  i_q_z,
    input  logic [tmi_pkg::VEC_W-1:0]          i_rel,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [tmi_pkg::WORD_W-1:0]  o_q_x,
    output logic signed [tmi_pkg::WORD_W-1:0]  o_q_y,
    output logic signed [tmi_pkg::WORD_W-1:0]  o_q_z,
    output logic                               o_hit,
    output logic [tmi_pkg::VEC_W-1:0]          o_rel
);

    logic                               r_valid;
    logic signed [tmi_pkg::WORD_W-1:0]  r_q_x, r_q_y, r_q_z;
    logic                               r_hit;
    logic [tmi_pkg::VEC_W-1:0]          r_rel;
    logic signed [tmi_pkg::WORD_W-1:0]  n_q_x, n_q_y, n_q_z;
    logic                               hit_x, hit_y, hit_z;
    logic                               stage_ready;

    function automatic logic signed [tmi_pkg::WORD_W-1:0] wrap_one(
        input logic signed [tmi_pkg::WORD_W-1:0] q
    );
        if (q < -tmi_pkg::HALF_Q30) begin
            return q + tmi_pkg::ONE_Q30;
        end else if (q >= tmi_pkg::HALF_Q30) begin
            return q - tmi_pkg::ONE_Q30;
        end else begin
            return q;
        end
    endfunction

    always_comb begin
        hit_x = (i_q_x < -tmi_pkg::HALF_Q30) || (i_q_x >= tmi_pkg::HALF_Q30);
        hit_y = (i_q_y < -tmi_pkg::HALF_Q30) || (i_q_y >= tmi_pkg::HALF_Q30);
        hit_z = (i_q_z < -tmi_pkg::HALF_Q30) || (i_q_z >= tmi_pkg::HALF_Q30);
        n_q_x = wrap_one(i_q_x);
        n_q_y = wrap_one(i_q_y);
        n_q_z = wrap_one(i_q_z);
    end

    assign stage_ready = !r_valid || i_ready;
    assign o_ready     = stage_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (stage_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready && i_valid) begin
            r_q_x <= n_q_x;
            r_q_y <= n_q_y;
            r_q_z <= n_q_z;
            r_hit <= hit_x || hit_y || hit_z;
            r_rel <= i_rel;
        end
    end

    assign o_valid = r_valid;
    assign o_q_x   = r_q_x;
    assign o_q_y   = r_q_y;
    assign o_q_z   = r_q_z;
    assign o_hit   = r_hit;
    assign o_rel   = r_rel;

endmodule
